@@ src/emrb_pkg.sv @@
// shared types and constants for the ethernet mac register block
// no dependencies
package emrb_pkg;

  typedef enum logic [2:0] {
    FUNC_RD    = 3'd0,
    FUNC_WR    = 3'd1,
    FUNC_LINK  = 3'd2,
    FUNC_TXDN  = 3'd3,
    FUNC_LERR  = 3'd4
  } func_e;

  localparam logic [4:0] A_RCVFIFO = 5'd0;
  localparam logic [4:0] A_XMTFS   = 5'd3;
  localparam logic [4:0] A_XMTRC   = 5'd4;
  localparam logic [4:0] A_RCVFC   = 5'd5;
  localparam logic [4:0] A_RCVFS   = 5'd6;
  localparam logic [4:0] A_FIFOFC  = 5'd7;
  localparam logic [4:0] A_IR      = 5'd8;
  localparam logic [4:0] A_IMR     = 5'd9;
  localparam logic [4:0] A_PR      = 5'd10;
  localparam logic [4:0] A_BIUCC   = 5'd11;
  localparam logic [4:0] A_FIFOCC  = 5'd12;
  localparam logic [4:0] A_MACCC   = 5'd13;
  localparam logic [4:0] A_PLSCC   = 5'd14;
  localparam logic [4:0] A_PHYCC   = 5'd15;
  localparam logic [4:0] A_CHIPID0 = 5'd16;
  localparam logic [4:0] A_CHIPID1 = 5'd17;
  localparam logic [4:0] A_IAC     = 5'd18;
  localparam logic [4:0] A_LADRF   = 5'd20;
  localparam logic [4:0] A_PADR    = 5'd21;
  localparam logic [4:0] A_MPC     = 5'd24;

  localparam logic [7:0] IRQ_TX      = 8'h01;
  localparam logic [7:0] IRQ_RX      = 8'h02;
  localparam logic [7:0] IRQ_ERR     = 8'h80;
  localparam logic [7:0] IAC_PHY     = 8'h04;
  localparam logic [7:0] IAC_LOG     = 8'h02;
  localparam logic [7:0] BIU_SOFTRST = 8'h01;
  localparam logic [7:0] MAC_PROMISC = 8'h80;
  localparam logic [7:0] BCAST_BYTE  = 8'hFF;
  localparam logic [7:0] XMTFS_ERR   = 8'h80;

  localparam logic [1:0] CFG_CHIPID = 2'd0;
  localparam logic [1:0] CFG_POLL   = 2'd1;
  localparam logic [1:0] CFG_PHYCC  = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [4:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] link_byte;
    logic       link_last;
    logic       tx_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       irq;
    logic       frame_dropped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // register the item
    logic execute;   // apply the registered item
    logic load_rd;   // take the store read data into the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mem_rd_pending; // fifo pop needs store read data
  } dp_status_t;

endpackage

@@ src/emrb_ram.sv @@
// generic single port write, single port registered read ram
// no dependencies
module emrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/emrb_ctrl.sv @@
// controller: sequences accept, execute and result strobe
// depends on emrb_pkg
module emrb_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  output emrb_pkg::ctrl_cmd_t     cmd_o,
  input  emrb_pkg::dp_status_t    status_i,
  output logic                    done_o
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_e;

  state_e state_q;
  logic   done_q;

  assign busy_o        = (state_q != S_IDLE);
  assign cmd_o.capture = start_i && (state_q == S_IDLE);
  assign cmd_o.execute = (state_q == S_EXEC);
  assign cmd_o.load_rd = (state_q == S_WAIT);
  assign done_o        = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_EXEC;
        S_EXEC: begin
          // a fifo pop waits in S_WAIT for the store read data
          if (status_i.mem_rd_pending) begin
            state_q <= S_WAIT;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_WAIT: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/emrb_dp.sv @@
// datapath: register file, address pointer, receive store and frame queue
// depends on emrb_pkg and emrb_ram
module emrb_dp #(
  parameter int RxBytes  = 4096,
  parameter int RxFrames = 8,
  parameter int MaxFrame = 1600
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  emrb_pkg::ctrl_cmd_t   cmd_i,
  output emrb_pkg::dp_status_t  status_o,
  input  emrb_pkg::in_item_t    item_i,
  input  logic                  done_i,
  input  logic [15:0]           chip_identity_i,
  input  logic [7:0]            poll_value_i,
  input  logic [7:0]            phy_config_value_i,
  output emrb_pkg::out_item_t   result_o
);
  localparam int BW = $clog2(RxBytes);
  localparam int HW = $clog2(RxBytes + 1);
  localparam int FW = (RxFrames > 1) ? $clog2(RxFrames) : 1;
  localparam int CW = $clog2(RxFrames + 1);
  localparam int LW = 11;

  emrb_pkg::in_item_t it_q;

  logic [BW-1:0] byte_head_q, byte_tail_q;
  logic [HW-1:0] bytes_held_q;
  logic [FW-1:0] frame_head_q;
  logic [CW-1:0] frame_count_q;
  logic [LW-1:0] read_offset_q, staged_length_q;
  logic          staged_ovf_q;
  logic [1:0]    dest_flags_q;
  logic [47:0]   station_q;
  logic [2:0]    ptr_q;
  logic [7:0]    xmtfs_q, xmtrc_q, rcvfc_q, rcvfs_q, ir_q, imr_q;
  logic [7:0]    biucc_q, fifocc_q, maccc_q, plscc_q, iac_q, mpc_q;
  logic [LW-1:0] flen_q [RxFrames];
  logic [7:0]    rd_q;
  logic          drop_q;

  function automatic logic [7:0] station_sel(logic [47:0] s, logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = s[7:0];
      3'd1:    b = s[15:8];
      3'd2:    b = s[23:16];
      3'd3:    b = s[31:24];
      3'd4:    b = s[39:32];
      3'd5:    b = s[47:40];
      default: b = '0;
    endcase
    return b;
  endfunction

  // store
  logic          st_we;
  logic [BW-1:0] st_waddr;
  logic [7:0]    st_rdata;
  logic [BW+LW:0] wsum;

  // tail plus staged length stays below twice the store size
  assign wsum     = (BW+LW+1)'(byte_tail_q) + (BW+LW+1)'(staged_length_q);
  assign st_waddr = BW'((wsum >= (BW+LW+1)'(RxBytes)) ? wsum - (BW+LW+1)'(RxBytes) : wsum);

  logic pop_go;
  assign pop_go = cmd_i.execute && (it_q.func == emrb_pkg::FUNC_RD) &&
                  (it_q.reg_addr == emrb_pkg::A_RCVFIFO) && (frame_count_q != '0);
  assign status_o.mem_rd_pending = pop_go;

  logic staging, fits_byte;
  assign staging   = staged_length_q < LW'(MaxFrame);
  assign fits_byte = (HW+1)'(staged_length_q) < (HW+1)'(RxBytes) - (HW+1)'(bytes_held_q);
  assign st_we = cmd_i.execute && (it_q.func == emrb_pkg::FUNC_LINK) && staging && fits_byte;

  emrb_ram #(.Width(8), .Depth(RxBytes)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (it_q.link_byte),
    .raddr_i (byte_head_q),
    .rdata_o (st_rdata)
  );

  logic [7:0] stn_byte;
  logic [7:0] ptr_byte;
  always_comb begin
    stn_byte = station_sel(station_q, staged_length_q[2:0]);
    ptr_byte = station_sel(station_q, ptr_q);
  end

  // address access write value, the physical bit yields to the logical bit
  logic [7:0] iac_wr;
  always_comb begin
    iac_wr = it_q.wr_data;
    if (((iac_wr & emrb_pkg::IAC_LOG) != '0) && ((iac_wr & emrb_pkg::IAC_PHY) != '0))
      iac_wr = iac_wr & ~emrb_pkg::IAC_PHY;
  end

  // combinational helpers for the frame commit
  logic [LW-1:0] new_len;
  logic [1:0]    new_flags;
  logic          new_ovf, accept, fits;
  always_comb begin
    new_len   = staged_length_q;
    new_flags = dest_flags_q;
    new_ovf   = staged_ovf_q;
    if (staging) begin
      if (staged_length_q < LW'(6)) begin
        if (it_q.link_byte != emrb_pkg::BCAST_BYTE) new_flags[0] = 1'b0;
        if (it_q.link_byte != stn_byte) new_flags[1] = 1'b0;
      end
      if (!fits_byte) new_ovf = 1'b1;
      new_len = staged_length_q + LW'(1);
    end
    accept = (new_len >= LW'(6)) &&
             (new_flags[0] || ((maccc_q & emrb_pkg::MAC_PROMISC) != '0) || new_flags[1]);
    fits   = !new_ovf && (frame_count_q < CW'(RxFrames)) &&
             ((HW+1)'(new_len) <= (HW+1)'(RxBytes) - (HW+1)'(bytes_held_q));
  end

  logic [FW:0]   tail_sum;
  logic [FW-1:0] frame_tail;
  assign tail_sum   = (FW+1)'(frame_head_q) + (FW+1)'(frame_count_q);
  assign frame_tail = FW'((tail_sum >= (FW+1)'(RxFrames)) ? tail_sum - (FW+1)'(RxFrames)
                                                          : tail_sum);

  logic [BW+LW:0] tail_adv;
  assign tail_adv = (BW+LW+1)'(byte_tail_q) + (BW+LW+1)'(new_len);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) it_q <= item_i;
    if (cmd_i.execute && it_q.func == emrb_pkg::FUNC_LINK && it_q.link_last &&
        accept && fits) begin
      flen_q[frame_tail] <= new_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_head_q <= '0; byte_tail_q <= '0; bytes_held_q <= '0;
      frame_head_q <= '0; frame_count_q <= '0; read_offset_q <= '0;
      staged_length_q <= '0; staged_ovf_q <= 1'b0; dest_flags_q <= 2'b11;
      station_q <= '0; ptr_q <= '0;
      xmtfs_q <= '0; xmtrc_q <= '0; rcvfc_q <= '0; rcvfs_q <= '0;
      ir_q <= '0; imr_q <= '0; biucc_q <= '0; fifocc_q <= '0;
      maccc_q <= '0; plscc_q <= '0; iac_q <= '0; mpc_q <= '0;
      rd_q <= '0; drop_q <= 1'b0;
    end else if (cmd_i.load_rd) begin
      rd_q <= st_rdata;
    end else if (cmd_i.execute) begin
      rd_q   <= '0;
      drop_q <= 1'b0;
      case (it_q.func)
        emrb_pkg::FUNC_RD: begin
          unique case (it_q.reg_addr)
            emrb_pkg::A_RCVFIFO: begin
              if (pop_go) begin
                byte_head_q <= BW'((BW+1)'(byte_head_q) + (BW+1)'(1) == (BW+1)'(RxBytes)
                               ? '0 : (BW+1)'(byte_head_q) + (BW+1)'(1));
                if (bytes_held_q != '0) bytes_held_q <= bytes_held_q - HW'(1);
                if (read_offset_q + LW'(1) >= flen_q[frame_head_q]) begin
                  read_offset_q <= '0;
                  frame_head_q  <= ((FW+1)'(frame_head_q) + (FW+1)'(1) == (FW+1)'(RxFrames))
                                   ? '0 : frame_head_q + FW'(1);
                  frame_count_q <= frame_count_q - CW'(1);
                end else begin
                  read_offset_q <= read_offset_q + LW'(1);
                end
              end
            end
            emrb_pkg::A_XMTFS:   rd_q <= xmtfs_q;
            emrb_pkg::A_XMTRC:   rd_q <= xmtrc_q;
            emrb_pkg::A_RCVFC:   rd_q <= rcvfc_q;
            emrb_pkg::A_RCVFS:   rd_q <= rcvfs_q;
            emrb_pkg::A_FIFOFC:  rd_q <= 8'(frame_count_q);
            emrb_pkg::A_IR: begin
              rd_q <= ir_q;
              ir_q <= '0;
            end
            emrb_pkg::A_IMR:     rd_q <= imr_q;
            emrb_pkg::A_PR:      rd_q <= poll_value_i;
            emrb_pkg::A_BIUCC:   rd_q <= biucc_q;
            emrb_pkg::A_FIFOCC:  rd_q <= fifocc_q;
            emrb_pkg::A_MACCC:   rd_q <= maccc_q;
            emrb_pkg::A_PLSCC:   rd_q <= plscc_q;
            emrb_pkg::A_PHYCC:   rd_q <= phy_config_value_i;
            emrb_pkg::A_CHIPID0: rd_q <= chip_identity_i[7:0];
            emrb_pkg::A_CHIPID1: rd_q <= chip_identity_i[15:8];
            emrb_pkg::A_IAC:     rd_q <= iac_q;
            emrb_pkg::A_PADR: begin
              if (((iac_q & emrb_pkg::IAC_PHY) != '0) && ptr_q < 3'd6) begin
                rd_q <= ptr_byte;
                if (ptr_q == 3'd5) begin
                  iac_q <= iac_q & ~emrb_pkg::IAC_PHY;
                  ptr_q <= '0;
                end else begin
                  ptr_q <= ptr_q + 3'd1;
                end
              end
            end
            emrb_pkg::A_MPC:     rd_q <= mpc_q;
            default: ;
          endcase
        end
        emrb_pkg::FUNC_WR: begin
          unique case (it_q.reg_addr)
            emrb_pkg::A_RCVFC:  rcvfc_q  <= it_q.wr_data;
            emrb_pkg::A_IMR:    imr_q    <= it_q.wr_data;
            emrb_pkg::A_BIUCC: begin
              if ((it_q.wr_data & emrb_pkg::BIU_SOFTRST) != '0) begin
                byte_head_q <= '0; byte_tail_q <= '0; bytes_held_q <= '0;
                frame_head_q <= '0; frame_count_q <= '0; read_offset_q <= '0;
                staged_length_q <= '0; staged_ovf_q <= 1'b0; dest_flags_q <= 2'b11;
                ir_q <= '0; xmtrc_q <= '0; xmtfs_q <= '0; rcvfs_q <= '0;
              end
              biucc_q <= it_q.wr_data & ~emrb_pkg::BIU_SOFTRST;
            end
            emrb_pkg::A_FIFOCC: fifocc_q <= it_q.wr_data;
            emrb_pkg::A_MACCC:  maccc_q  <= it_q.wr_data;
            emrb_pkg::A_PLSCC:  plscc_q  <= it_q.wr_data;
            emrb_pkg::A_IAC: begin
              if ((iac_wr & (emrb_pkg::IAC_LOG | emrb_pkg::IAC_PHY)) != '0) ptr_q <= '0;
              iac_q <= iac_wr;
            end
            emrb_pkg::A_LADRF: begin
              // filter bytes reach no port, only the pointer walk is visible
              if ((iac_q & emrb_pkg::IAC_LOG) != '0) begin
                if (ptr_q == 3'd7) begin
                  iac_q <= iac_q & ~emrb_pkg::IAC_LOG;
                  ptr_q <= '0;
                end else begin
                  ptr_q <= ptr_q + 3'd1;
                end
              end
            end
            emrb_pkg::A_PADR: begin
              if (((iac_q & emrb_pkg::IAC_PHY) != '0) && ptr_q < 3'd6) begin
                station_q[8*ptr_q +: 8] <= it_q.wr_data;
                if (ptr_q == 3'd5) begin
                  iac_q <= iac_q & ~emrb_pkg::IAC_PHY;
                  ptr_q <= '0;
                end else begin
                  ptr_q <= ptr_q + 3'd1;
                end
              end
            end
            default: ;
          endcase
        end
        emrb_pkg::FUNC_LINK: begin
          if (!it_q.link_last) begin
            staged_length_q <= new_len;
            dest_flags_q    <= new_flags;
            staged_ovf_q    <= new_ovf;
          end else begin
            staged_length_q <= '0;
            staged_ovf_q    <= 1'b0;
            dest_flags_q    <= 2'b11;
            if (!accept || !fits) begin
              mpc_q  <= mpc_q + 8'd1;
              drop_q <= 1'b1;
            end else begin
              frame_count_q <= frame_count_q + CW'(1);
              byte_tail_q   <= BW'((tail_adv >= (BW+LW+1)'(RxBytes))
                                   ? tail_adv - (BW+LW+1)'(RxBytes) : tail_adv);
              bytes_held_q  <= bytes_held_q + HW'(new_len);
              rcvfs_q       <= '0;
              ir_q          <= ir_q | emrb_pkg::IRQ_RX;
            end
          end
        end
        emrb_pkg::FUNC_TXDN: begin
          if (it_q.tx_ok) begin
            xmtfs_q <= '0;
            ir_q    <= ir_q | emrb_pkg::IRQ_TX;
          end else begin
            xmtfs_q <= xmtfs_q | emrb_pkg::XMTFS_ERR;
            ir_q    <= ir_q | emrb_pkg::IRQ_ERR;
          end
        end
        emrb_pkg::FUNC_LERR: ir_q <= ir_q | emrb_pkg::IRQ_ERR;
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.rd_data       = rd_q;
    result_o.irq           = (ir_q & imr_q) != '0;
    result_o.frame_dropped = drop_q;
    if (!done_i) result_o = '0;
  end
endmodule

@@ src/ethernet_mac_register_block_core.sv @@
// top level of the ethernet mac register block
// depends on emrb_pkg, emrb_ctrl, emrb_dp, emrb_ram
//
// one item is accepted when start_i is high and busy_o is low; its result
// appears for exactly one cycle with done_o high and cannot be held off.
// an item passes the execute state (and a wait state for the registered
// store read when a receive fifo read pops a byte) before its result, and
// busy_o stays high until the result is shown. the apb port holds the
// chip identity, poll and phy configuration values; pready is always high.
module ethernet_mac_register_block_core #(
  parameter int RX_BYTES  = 4096,
  parameter int RX_FRAMES = 8,
  parameter int MAX_FRAME = 1600
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  emrb_pkg::in_item_t    item_i,
  output logic                  done_o,
  output emrb_pkg::out_item_t   result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  emrb_pkg::ctrl_cmd_t  cmd;
  emrb_pkg::dp_status_t status;

  logic [15:0] chip_id_q;
  logic [7:0]  poll_q, phycc_q;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_id_q <= '0;
      poll_q    <= '0;
      phycc_q   <= '0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        emrb_pkg::CFG_CHIPID: chip_id_q <= pwdata[15:0];
        emrb_pkg::CFG_POLL:   poll_q    <= pwdata[7:0];
        emrb_pkg::CFG_PHYCC:  phycc_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      emrb_pkg::CFG_CHIPID: prdata = {16'd0, chip_id_q};
      emrb_pkg::CFG_POLL:   prdata = {24'd0, poll_q};
      emrb_pkg::CFG_PHYCC:  prdata = {24'd0, phycc_q};
      default:              prdata = '0;
    endcase
  end

  // sequencer
  emrb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status),
    .done_o   (done_o)
  );

  // register file, address pointer and receive queues
  emrb_dp #(
    .RxBytes  (RX_BYTES),
    .RxFrames (RX_FRAMES),
    .MaxFrame (MAX_FRAME)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .item_i             (item_i),
    .done_i             (done_o),
    .chip_identity_i    (chip_id_q),
    .poll_value_i       (poll_q),
    .phy_config_value_i (phycc_q),
    .result_o           (result_o)
  );
endmodule

@@ sim/emrb_checker.sv @@
`timescale 1ns / 1ps
// checker for the ethernet mac register block: predicts each item's result
// and compares it with the block's output; depends on emrb_pkg only
module emrb_checker
  import emrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_item_t    item_i,
  input  logic        done_i,
  input  out_item_t   result_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          waiting
);

  localparam int STORE_BYTES  = 4096;
  localparam int QUEUE_FRAMES = 8;
  localparam int FRAME_LIMIT  = 1600;
  localparam int EXP_DEPTH    = 4;

  // expected results in flight, oldest at exp_rd
  out_item_t   exp_mem [EXP_DEPTH];
  int unsigned exp_rd, exp_wr, exp_cnt;

  // configuration copy
  logic [15:0] chip_id;
  logic [7:0]  poll_val, phycc_val;

  // receive side
  logic [7:0]  rx_mem [STORE_BYTES];
  int unsigned frame_len [QUEUE_FRAMES];
  int unsigned byte_rd, byte_wr, bytes_in, frame_rd, frames_in, pop_ofs, stage_len;
  bit          stage_ovf;
  bit [1:0]    dest_ok;

  // register file
  logic [47:0] station;
  logic [63:0] mcast;
  logic [7:0]  xmtfs, xmtrc, rcvfc, rcvfs, ir, imr, biucc, fifocc, maccc, plscc, iac, mpc;
  int unsigned ptr;

  task automatic clear_rx();
    byte_rd = 0; byte_wr = 0; bytes_in = 0; frame_rd = 0; frames_in = 0;
    pop_ofs = 0; stage_len = 0; stage_ovf = 0; dest_ok = 2'b11;
  endtask

  function automatic logic [7:0] station_at(int unsigned i);
    return station[(i % 6) * 8 +: 8];
  endfunction

  task automatic pop_byte(output logic [7:0] b);
    b = '0;
    if (frames_in != 0) begin
      b = rx_mem[byte_rd];
      byte_rd = (byte_rd + 1) % STORE_BYTES;
      if (bytes_in != 0) bytes_in--;
      pop_ofs++;
      if (pop_ofs >= frame_len[frame_rd]) begin
        pop_ofs = 0;
        frame_rd = (frame_rd + 1) % QUEUE_FRAMES;
        frames_in--;
      end
    end
  endtask

  task automatic bus_read(logic [4:0] a, output logic [7:0] v);
    v = '0;
    case (a)
      A_RCVFIFO: pop_byte(v);
      A_XMTFS:   v = xmtfs;
      A_XMTRC:   v = xmtrc;
      A_RCVFC:   v = rcvfc;
      A_RCVFS:   v = rcvfs;
      A_FIFOFC:  v = 8'(frames_in);
      A_IR: begin
        v = ir;
        ir = '0;
      end
      A_IMR:     v = imr;
      A_PR:      v = poll_val;
      A_BIUCC:   v = biucc;
      A_FIFOCC:  v = fifocc;
      A_MACCC:   v = maccc;
      A_PLSCC:   v = plscc;
      A_PHYCC:   v = phycc_val;
      A_CHIPID0: v = chip_id[7:0];
      A_CHIPID1: v = chip_id[15:8];
      A_IAC:     v = iac;
      A_PADR: begin
        if ((iac & IAC_PHY) != 0 && ptr < 6) begin
          v = station_at(ptr);
          ptr++;
          if (ptr >= 6) begin
            iac = iac & ~IAC_PHY;
            ptr = 0;
          end
        end
      end
      A_MPC:     v = mpc;
      default:   v = '0;
    endcase
  endtask

  task automatic bus_write(logic [4:0] a, logic [7:0] d);
    logic [7:0] v;
    v = d;
    case (a)
      A_RCVFC:  rcvfc = v;
      A_IMR:    imr = v;
      A_BIUCC: begin
        if ((v & BIU_SOFTRST) != 0) begin
          v = v & ~BIU_SOFTRST;
          clear_rx();
          ir = '0; xmtrc = '0; xmtfs = '0; rcvfs = '0;
        end
        biucc = v;
      end
      A_FIFOCC: fifocc = v;
      A_MACCC:  maccc = v;
      A_PLSCC:  plscc = v;
      A_IAC: begin
        if ((v & IAC_LOG) != 0 && (v & IAC_PHY) != 0) v = v & ~IAC_PHY;
        if ((v & (IAC_LOG | IAC_PHY)) != 0) ptr = 0;
        iac = v;
      end
      A_LADRF: begin
        if ((iac & IAC_LOG) != 0 && ptr < 8) begin
          mcast[ptr * 8 +: 8] = v;
          ptr++;
          if (ptr >= 8) begin
            iac = iac & ~IAC_LOG;
            ptr = 0;
          end
        end
      end
      A_PADR: begin
        if ((iac & IAC_PHY) != 0 && ptr < 6) begin
          station[ptr * 8 +: 8] = v;
          ptr++;
          if (ptr >= 6) begin
            iac = iac & ~IAC_PHY;
            ptr = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // stage one link byte; on the last byte decide commit or drop
  task automatic link_in(logic [7:0] b, logic last, output logic dropped);
    int unsigned len;
    bit accept, fits;
    dropped = 0;
    if (stage_len < FRAME_LIMIT) begin
      if (stage_len < 6) begin
        if (b != BCAST_BYTE) dest_ok[0] = 0;
        if (b != station_at(stage_len)) dest_ok[1] = 0;
      end
      if (stage_len < STORE_BYTES - bytes_in)
        rx_mem[(byte_wr + stage_len) % STORE_BYTES] = b;
      else
        stage_ovf = 1;
      stage_len++;
    end
    if (last) begin
      len = stage_len;
      accept = len >= 6 && (dest_ok[0] || (maccc & MAC_PROMISC) != 0 || dest_ok[1]);
      fits = !stage_ovf && frames_in < QUEUE_FRAMES && len <= STORE_BYTES - bytes_in;
      stage_len = 0; stage_ovf = 0; dest_ok = 2'b11;
      if (!accept || !fits) begin
        mpc = mpc + 8'd1;
        dropped = 1;
      end else begin
        frame_len[(frame_rd + frames_in) % QUEUE_FRAMES] = len;
        frames_in++;
        byte_wr = (byte_wr + len) % STORE_BYTES;
        bytes_in += len;
        rcvfs = '0;
        ir = ir | IRQ_RX;
      end
    end
  endtask

  task automatic predict(in_item_t it, output out_item_t r);
    r = '0;
    case (func_e'(it.func))
      FUNC_RD:   bus_read(it.reg_addr, r.rd_data);
      FUNC_WR:   bus_write(it.reg_addr, it.wr_data);
      FUNC_LINK: link_in(it.link_byte, it.link_last, r.frame_dropped);
      FUNC_TXDN: begin
        if (it.tx_ok) begin
          xmtfs = '0;
          ir = ir | IRQ_TX;
        end else begin
          xmtfs = xmtfs | XMTFS_ERR;
          ir = ir | IRQ_ERR;
        end
      end
      FUNC_LERR: ir = ir | IRQ_ERR;
      default: ;
    endcase
    r.irq = (ir & imr) != 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r, got;
    if (!rst_ni) begin
      exp_rd = 0; exp_wr = 0; exp_cnt = 0;
      fail_count = 0;
      chip_id = '0; poll_val = '0; phycc_val = '0;
      clear_rx();
      station = '0; mcast = '0; ptr = 0;
      xmtfs = '0; xmtrc = '0; rcvfc = '0; rcvfs = '0; ir = '0; imr = '0;
      biucc = '0; fifocc = '0; maccc = '0; plscc = '0; iac = '0; mpc = '0;
    end else begin
      // a result belongs to an earlier item, so compare before predicting
      if (done_i) begin
        got = result_i;
        if (exp_cnt == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          exp_r = exp_mem[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt--;
          if (got.rd_data !== exp_r.rd_data) begin
            $error("rd_data: expected %02h, got %02h", exp_r.rd_data, got.rd_data);
            fail_count++;
          end
          if (got.irq !== exp_r.irq) begin
            $error("irq: expected %0b, got %0b", exp_r.irq, got.irq);
            fail_count++;
          end
          if (got.frame_dropped !== exp_r.frame_dropped) begin
            $error("frame_dropped: expected %0b, got %0b",
                   exp_r.frame_dropped, got.frame_dropped);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict(item_i, exp_r);
        if (exp_cnt == EXP_DEPTH) begin
          $error("too many items outstanding");
          fail_count++;
        end else begin
          exp_mem[exp_wr] = exp_r;
          exp_wr = (exp_wr + 1) % EXP_DEPTH;
          exp_cnt++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          4 * CFG_CHIPID: chip_id = pwdata[15:0];
          4 * CFG_POLL:   poll_val = pwdata[7:0];
          4 * CFG_PHYCC:  phycc_val = pwdata[7:0];
          default: ;
        endcase
      end
    end
    waiting = exp_cnt;
  end

endmodule

@@ sim/tb_ethernet_mac_register_block_core.sv @@
`timescale 1ns / 1ps
// testbench top for the ethernet mac register block: drives items and the
// apb port, depends on emrb_pkg, emrb_checker and the block itself
module tb_ethernet_mac_register_block_core;
  import emrb_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  in_item_t    item_i = '0;
  logic        done_o;
  out_item_t   result_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count, waiting;
  int   items_sent = 0;
  bit   gaps_on = 1;
  bit   mid_cfg_done = 0;
  logic [47:0] station_guess = '0;   // what we last programmed into the station address

  ethernet_mac_register_block_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  emrb_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i, .done_i(done_o),
    .result_i(result_o), .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .waiting
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // every field random, so unused bits toggle too
  function automatic in_item_t rand_item();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    return it;
  endfunction

  // present one item and hold it until the block takes it
  task automatic issue(in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i = 0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    start_i = 1;
    item_i  = it;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 0;
    items_sent++;
  endtask

  task automatic op(func_e f, logic [4:0] a = '0, logic [7:0] d = '0);
    in_item_t it;
    it = rand_item();
    it.func = f;
    it.reg_addr = a;
    it.wr_data = d;
    issue(it);
  endtask

  task automatic link(logic [7:0] b, logic last);
    in_item_t it;
    it = rand_item();
    it.func = FUNC_LINK;
    it.link_byte = b;
    it.link_last = last;
    issue(it);
  endtask

  // kind 0 broadcast, 1 our station, otherwise random destination
  task automatic send_frame(int len, int kind);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i < 6 && kind == 0) b = BCAST_BYTE;
      if (i < 6 && kind == 1) b = station_guess[i * 8 +: 8];
      link(b, i == len - 1);
    end
  endtask

  task automatic drain(int n);
    repeat (n) op(FUNC_RD, A_RCVFIFO);
  endtask

  task automatic program_station(logic [47:0] s);
    op(FUNC_WR, A_IAC, IAC_PHY);
    for (int i = 0; i < 6; i++) op(FUNC_WR, A_PADR, s[i * 8 +: 8]);
    station_guess = s;
  endtask

  // two-phase apb write
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0;
    paddr = 4'(4 * idx); pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // every item yields a result, so an empty queue means the block is idle
  task automatic settle();
    wait (waiting == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_all(logic [15:0] id, logic [7:0] pv, logic [7:0] pc);
    settle();
    cfg_write(CFG_CHIPID, {16'($urandom), id});
    cfg_write(CFG_POLL, {24'($urandom), pv});
    cfg_write(CFG_PHYCC, {24'($urandom), pc});
  endtask

  initial begin
    int pick;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;

    // low extremes of the configuration
    cfg_all(16'h0000, 8'h00, 8'h00);

    // directed: identity reads, empty fifo, interrupts, address access corners
    op(FUNC_RD, A_CHIPID0);
    op(FUNC_RD, A_PR);
    op(FUNC_RD, A_RCVFIFO);
    op(FUNC_RD, 5'd31);
    op(FUNC_WR, A_IMR, 8'hFF);
    op(FUNC_TXDN);
    op(FUNC_RD, A_IR);               // read clears status
    begin
      in_item_t it;
      it = rand_item();
      it.func = FUNC_TXDN;
      it.tx_ok = 0;
      issue(it);
      it.func = 3'd7;                // unknown function
      issue(it);
    end
    op(FUNC_RD, A_XMTFS);
    op(FUNC_LERR);
    op(FUNC_WR, A_IAC, IAC_PHY | IAC_LOG);   // physical bit gets dropped
    op(FUNC_WR, A_PADR, 8'hAA);              // ignored without its access bit
    op(FUNC_RD, A_IAC);
    op(FUNC_WR, A_IAC, IAC_PHY);
    op(FUNC_RD, A_PADR);
    send_frame(3, 0);                // too short, counted missed
    send_frame(6, 0);
    op(FUNC_RD, A_FIFOFC);
    op(FUNC_RD, A_RCVFIFO);
    op(FUNC_RD, A_MPC);

    // high extremes of the configuration
    cfg_all(16'hFFFF, 8'hFF, 8'hFF);
    op(FUNC_RD, A_CHIPID1);
    op(FUNC_RD, A_PHYCC);
    op(FUNC_RD, A_PR);

    // frame queue full, drain across frames, soft reset with frames held
    drain(6);
    program_station(48'h0123_4567_89AB);
    for (int i = 0; i < 9; i++) send_frame(8, i % 2);
    op(FUNC_RD, A_FIFOFC);
    op(FUNC_RD, A_MPC);
    drain(20);
    for (int i = 0; i < 3; i++) send_frame(8, 1);
    op(FUNC_WR, A_BIUCC, 8'hFF);
    op(FUNC_RD, A_BIUCC);
    op(FUNC_RD, A_RCVFIFO);

    cfg_all(16'($urandom), 8'($urandom), 8'($urandom));
    while (items_sent < 1300) begin
      if (items_sent > 1150) gaps_on = 0;
      if (items_sent > 450 && !mid_cfg_done && gaps_on) begin
        cfg_all(16'($urandom), 8'($urandom), 8'($urandom));
        mid_cfg_done = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pick = $urandom_range(0, 9);
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(31, 300)
                                                : $urandom_range(1, 30),
                   pick < 4 ? 0 : (pick < 8 ? 1 : 2));
      end else if (pick < 55) begin
        drain($urandom_range(1, 40));
      end else if (pick < 61) begin
        program_station({$urandom, 16'($urandom)});
      end else if (pick < 64) begin
        op(FUNC_WR, A_IAC, IAC_PHY);
        repeat (6) op(FUNC_RD, A_PADR);
      end else if (pick < 68) begin
        op(FUNC_WR, A_IAC, IAC_LOG);
        repeat ($urandom_range(1, 8)) op(FUNC_WR, A_LADRF, 8'($urandom));
      end else if (pick < 73) begin
        op(FUNC_WR, A_MACCC, {1'($urandom), 7'($urandom)});
      end else if (pick < 90) begin
        issue(rand_item());
      end else begin
        op(func_e'($urandom_range(FUNC_TXDN, FUNC_LERR)));
        op(FUNC_RD, $urandom_range(0, 1) ? A_IR : A_IMR);
      end
    end

    wait (waiting == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
